// File: rtl/bhpq_pkg.sv
package bhpq_pkg;

  localparam int DEF_CAPACITY     = 1024;
  localparam int DEF_KEY_BITS     = 32;
  localparam int DEF_PAYLOAD_BITS = 32;

  localparam int FIELD_W = 32;
  localparam int TOTAL_W = 11;
  localparam int STAT_W  = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] item_key;
    logic [FIELD_W-1:0] item_payload;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] removed_key;
    logic [FIELD_W-1:0] removed_payload;
    logic [FIELD_W-1:0] head_key;
    logic [FIELD_W-1:0] head_payload;
    logic [TOTAL_W-1:0] entry_total;
    logic               is_empty;
  } out_item_t;

endpackage

// File: rtl/binary_heap_priority_queue.sv
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     in_item  (bhpq_pkg::in_item_t)
// out       output     out_valid / out_stall   out_item (bhpq_pkg::out_item_t)
// cfg       input      cfg_we                  cfg_wdata (max_first)
//
// one item at a time; the heap lives in a single memory with one read and one write port
// a refused item or a delete of the last entry goes straight from S_IDLE to S_DONE for the result load
// insert: per level climbed, S_UP_RD reads the parent and S_UP_CMP compares and writes; S_UP_RD writes at the root
// delete: S_LAST fetches the last entry, then per level S_DN_RD, S_DN_C1, S_DN_C2 read children and S_DN_CMP writes
// the root is mirrored in registers; reset clears state, count, mode and out_valid, not the memory, no clearing pass
// a new item is taken while the previous result waits in the output register
module binary_heap_priority_queue #(
  parameter int CAPACITY     = bhpq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = bhpq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = bhpq_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  bhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bhpq_pkg::out_item_t out_item
);

  import bhpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UP_RD  = 9'b000000010,
    S_UP_CMP = 9'b000000100,
    S_LAST   = 9'b000001000,
    S_DN_RD  = 9'b000010000,
    S_DN_C1  = 9'b000100000,
    S_DN_C2  = 9'b001000000,
    S_DN_CMP = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  function automatic logic goes_first(input logic mode, input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b);
    goes_first = mode ? (a > b) : (a < b);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
    to_addr = AW'(idx - IW'(1));
  endfunction

  state_t state, state_next;
  logic [IW-1:0] count, count_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] ch_idx, ch_idx_next;
  logic max_first;
  logic [STAT_W-1:0] status, status_next;
  entry_t cur, cur_next;
  entry_t ch, ch_next;
  entry_t head;
  entry_t removed, removed_next;
  logic out_load;

  entry_t mem [CAPACITY];
  entry_t mem_rdata;
  logic mem_re;
  logic [IW-1:0] mem_ridx;
  logic mem_we;
  logic [IW-1:0] mem_widx;
  entry_t mem_wdata;

  logic [IW:0] c2;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[to_addr(mem_widx)] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[to_addr(mem_ridx)];
    end
  end

  assign c2 = {k, 1'b0};
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next   = state;
    count_next   = count;
    k_next       = k;
    ch_idx_next  = ch_idx;
    status_next  = status;
    cur_next     = cur;
    ch_next      = ch;
    removed_next = removed;
    mem_re       = 1'b0;
    mem_ridx     = k;
    mem_we       = 1'b0;
    mem_widx     = k;
    mem_wdata    = cur;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          status_next  = STATUS_OK;
          removed_next = '0;
          cur_next.key = KEY_BITS'(in_item.item_key);
          cur_next.pay = PAYLOAD_BITS'(in_item.item_payload);
          if (in_item.kind == KIND_INSERT) begin
            if (count == IW'(CAPACITY)) begin
              status_next = STATUS_FULL;
              state_next  = S_DONE;
            end else begin
              count_next = count + IW'(1);
              k_next     = count + IW'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              status_next = STATUS_EMPTY;
              state_next  = S_DONE;
            end else begin
              removed_next = head;
              count_next   = count - IW'(1);
              k_next       = IW'(1);
              if (count == IW'(1)) begin
                state_next = S_DONE;
              end else begin
                mem_re     = 1'b1;
                mem_ridx   = count;
                state_next = S_LAST;
              end
            end
          end
        end
      end
      S_UP_RD: begin
        if (k == IW'(1)) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_ridx   = k >> 1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (goes_first(max_first, cur.key, mem_rdata.key)) begin
          mem_wdata  = mem_rdata;
          k_next     = k >> 1;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LAST: begin
        cur_next   = mem_rdata;
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        if (c2 > {1'b0, count}) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_ridx   = c2[IW-1:0];
          state_next = S_DN_C1;
        end
      end
      S_DN_C1: begin
        ch_next     = mem_rdata;
        ch_idx_next = c2[IW-1:0];
        if (c2 < {1'b0, count}) begin
          mem_re     = 1'b1;
          mem_ridx   = c2[IW-1:0] + IW'(1);
          state_next = S_DN_C2;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_C2: begin
        if (goes_first(max_first, mem_rdata.key, ch.key)) begin
          ch_next     = mem_rdata;
          ch_idx_next = ch_idx + IW'(1);
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (goes_first(max_first, ch.key, cur.key)) begin
          mem_wdata  = ch;
          k_next     = ch_idx;
          state_next = S_DN_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      max_first <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        max_first <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    ch_idx  <= ch_idx_next;
    status  <= status_next;
    cur     <= cur_next;
    ch      <= ch_next;
    removed <= removed_next;
    if (mem_we && mem_widx == IW'(1)) begin
      head <= mem_wdata;
    end
    if (out_load) begin
      out_item.status          <= status;
      out_item.removed_key     <= FIELD_W'(removed.key);
      out_item.removed_payload <= FIELD_W'(removed.pay);
      out_item.head_key        <= (count != '0) ? FIELD_W'(head.key) : '0;
      out_item.head_payload    <= (count != '0) ? FIELD_W'(head.pay) : '0;
      out_item.entry_total     <= TOTAL_W'(count);
      out_item.is_empty        <= (count == '0);
    end
  end

endmodule
